// File: hdl/stp_pkg.sv
package stp_pkg;

    localparam int SLOT_W = 15;
    localparam int TPS_W  = 8;

    localparam logic [TPS_W-1:0]  TICKS_RESET = 8'd5;
    localparam logic [SLOT_W-1:0] SLOT_IDLE   = 15'd1;
    localparam logic [SLOT_W-1:0] SLOT_STEP   = 15'd2;

    typedef enum logic [2:0] {
        REQ_ALLOC = 3'd0,
        REQ_LOAD  = 3'd1,
        REQ_START = 3'd2,
        REQ_STOP  = 3'd3,
        REQ_TICK  = 3'd4
    } req_code_t;

    typedef struct packed {
        logic [2:0]        req_type;
        logic [1:0]        timer_index;
        logic [SLOT_W-1:0] load_value;
    } stp_req_t;

    typedef struct packed {
        logic       alloc_ok;
        logic [1:0] alloc_index;
        logic [3:0] expired_mask;
        logic       tick_enabled;
    } stp_rsp_t;

endpackage

// File: hdl/software_timer_pool.sv
// Pool of NUM_TIMERS countdown slots sharing one tick prescaler and enable.
// Request channel (s_valid/s_ready/s_data): allocate, load, start, stop or
//   tick; s_data carries req_type, timer_index and load_value.
// Response channel (m_valid/m_ready/m_data): exactly one response per
//   request, in order: alloc_ok, alloc_index, expired_mask, tick_enabled.
// Config channel (cfg_valid/cfg_ready/cfg_data): writes ticks_per_step,
//   always ready; write only while no request is in flight.
// Pipeline: two register stages, request register and response register;
//   a request's response is registered when it leaves the request register.
// Throughput: one request per cycle while responses are taken; the slot
//   update for all slots is done in parallel in the logic between the two registers.
// Reset: all slots free, prescaler zero, tick enable off, ticks_per_step 5,
//   both stages empty.
// Stall: when m_ready is low the response holds; one more request is taken
//   into the request register, then s_ready drops until m_ready returns.
module software_timer_pool
    import stp_pkg::*;
#(
    parameter int NUM_TIMERS = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  stp_req_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output stp_rsp_t         m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [TPS_W-1:0] cfg_data
);

    logic     req_valid;
    logic     req_take;
    stp_req_t req_data;

    stp_in_stage u_in_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .req_valid(req_valid),
        .req_data (req_data),
        .req_take (req_take)
    );

    stp_pool_core #(
        .NUM_TIMERS(NUM_TIMERS)
    ) u_pool_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req_valid(req_valid),
        .req_data (req_data),
        .req_take (req_take),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

endmodule

// File: hdl/stp_in_stage.sv
module stp_in_stage
    import stp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  stp_req_t s_data,
    output logic     req_valid,
    output stp_req_t req_data,
    input  logic     req_take
);

    logic     req_valid_reg;
    logic     req_valid_next;
    stp_req_t req_reg;

    assign s_ready   = !req_valid_reg || req_take;
    assign req_valid = req_valid_reg;
    assign req_data  = req_reg;

    always_comb begin
        req_valid_next = req_valid_reg;
        if (s_valid && s_ready) begin
            req_valid_next = 1'b1;
        end else if (req_take) begin
            req_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
        end else begin
            req_valid_reg <= req_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_data;
        end
    end

endmodule

// File: hdl/stp_free_enc.sv
module stp_free_enc #(
    parameter int NUM_TIMERS = 4
) (
    input  logic [NUM_TIMERS-1:0] slot_busy,
    output logic                  free_found,
    output logic [NUM_TIMERS-1:0] free_onehot,
    output logic [1:0]            free_index
);

    // lowest free slot wins
    always_comb begin
        free_found  = 1'b0;
        free_onehot = '0;
        free_index  = 2'd0;
        for (int s = NUM_TIMERS - 1; s >= 0; s--) begin
            if (!slot_busy[s]) begin
                free_found     = 1'b1;
                free_onehot    = '0;
                free_onehot[s] = 1'b1;
                free_index     = 2'(s);
            end
        end
    end

endmodule

// File: hdl/stp_pool_core.sv
module stp_pool_core
    import stp_pkg::*;
#(
    parameter int NUM_TIMERS = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             req_valid,
    input  stp_req_t         req_data,
    output logic             req_take,
    output logic             m_valid,
    input  logic             m_ready,
    output stp_rsp_t         m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [TPS_W-1:0] cfg_data
);

    logic [SLOT_W-1:0] slot_reg  [NUM_TIMERS];
    logic [SLOT_W-1:0] slot_next [NUM_TIMERS];
    logic [SLOT_W-1:0] step_val  [NUM_TIMERS];
    logic [TPS_W-1:0]  prescale_reg;
    logic [TPS_W-1:0]  prescale_next;
    logic [TPS_W-1:0]  tps_reg;
    logic              enable_reg;
    logic              enable_next;
    logic              m_valid_reg;
    logic              m_valid_next;
    stp_rsp_t          rsp_reg;
    stp_rsp_t          rsp_next;

    logic [NUM_TIMERS-1:0] slot_busy;
    logic [NUM_TIMERS-1:0] sel;
    logic [NUM_TIMERS-1:0] step_exp;
    logic [NUM_TIMERS-1:0] step_busy;
    logic [NUM_TIMERS-1:0] free_onehot;
    logic                  free_found;
    logic [1:0]            free_index;
    logic                  hit;
    logic [TPS_W-1:0]      period;
    logic [TPS_W-1:0]      pre_inc;
    logic                  step_due;
    logic [31:0]           exp_wide;

    assign req_take  = req_valid && (!m_valid_reg || m_ready);
    assign m_valid   = m_valid_reg;
    assign m_data    = rsp_reg;
    assign cfg_ready = 1'b1;

    stp_free_enc #(
        .NUM_TIMERS(NUM_TIMERS)
    ) u_free_enc (
        .slot_busy  (slot_busy),
        .free_found (free_found),
        .free_onehot(free_onehot),
        .free_index (free_index)
    );

    always_comb begin
        for (int s = 0; s < NUM_TIMERS; s++) begin
            slot_busy[s] = (slot_reg[s] != '0);
            sel[s]       = (32'(req_data.timer_index) == s);
            step_exp[s]  = (slot_reg[s] == SLOT_IDLE) || (slot_reg[s] == SLOT_STEP);
            if (step_exp[s]) begin
                step_val[s] = '0;
            end else if (slot_busy[s]) begin
                step_val[s] = slot_reg[s] - SLOT_IDLE;
            end else begin
                step_val[s] = slot_reg[s];
            end
            step_busy[s] = (step_val[s] != '0);
        end
    end

    assign hit      = |(sel & slot_busy);
    assign period   = (tps_reg == '0) ? TPS_W'(1) : tps_reg;
    assign pre_inc  = prescale_reg + TPS_W'(1);
    assign step_due = (pre_inc >= period);
    assign exp_wide = 32'(step_exp);

    always_comb begin
        slot_next     = slot_reg;
        prescale_next = prescale_reg;
        enable_next   = enable_reg;
        rsp_next      = '0;
        case (req_data.req_type)
            REQ_ALLOC: begin
                if (free_found) begin
                    for (int s = 0; s < NUM_TIMERS; s++) begin
                        if (free_onehot[s]) begin
                            slot_next[s] = SLOT_IDLE;
                        end
                    end
                    rsp_next.alloc_ok    = 1'b1;
                    rsp_next.alloc_index = free_index;
                end
            end
            REQ_LOAD: begin
                if (hit) begin
                    for (int s = 0; s < NUM_TIMERS; s++) begin
                        if (sel[s]) begin
                            slot_next[s] = req_data.load_value;
                        end
                    end
                end
            end
            REQ_START: begin
                if (hit) begin
                    enable_next = 1'b1;
                end
            end
            REQ_STOP: begin
                if (hit) begin
                    for (int s = 0; s < NUM_TIMERS; s++) begin
                        if (sel[s]) begin
                            slot_next[s] = '0;
                        end
                    end
                    if ((slot_busy & ~sel) == '0) begin
                        enable_next = 1'b0;
                    end
                end
            end
            REQ_TICK: begin
                if (enable_reg) begin
                    if (step_due) begin
                        prescale_next         = '0;
                        slot_next             = step_val;
                        rsp_next.expired_mask = exp_wide[3:0];
                        if ((|step_exp) && (step_busy == '0)) begin
                            enable_next = 1'b0;
                        end
                    end else begin
                        prescale_next = pre_inc;
                    end
                end
            end
            default: begin
            end
        endcase
        rsp_next.tick_enabled = enable_next;
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (req_take) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < NUM_TIMERS; s++) begin
                slot_reg[s] <= '0;
            end
            prescale_reg <= '0;
            enable_reg   <= 1'b0;
            tps_reg      <= TICKS_RESET;
            m_valid_reg  <= 1'b0;
        end else begin
            if (req_take) begin
                slot_reg     <= slot_next;
                prescale_reg <= prescale_next;
                enable_reg   <= enable_next;
            end
            if (cfg_valid && cfg_ready) begin
                tps_reg <= cfg_data;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (req_take) begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

// File: hdl/stp_checker.sv
module stp_checker
    import stp_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input stp_rsp_t m_data
);

    a_rsp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("response changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("response valid right after reset");

    a_stall_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("request side stalled without a stalled response");

    a_grant_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.alloc_ok |-> m_data.alloc_index == 2'd0)
        else $error("grant index without a grant");

    a_grant_no_expire: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.alloc_ok |-> m_data.expired_mask == 4'd0)
        else $error("allocate response reports expiry");

endmodule

bind software_timer_pool stp_checker u_stp_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);

// File: verif/tb_software_timer_pool.sv
`timescale 1ns / 1ps

module tb_software_timer_pool;
    import stp_pkg::*;

    localparam int POOL_SIZE = 4;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 100;
    localparam int NUM_PHASES = 9;
    localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
    localparam logic [2:0] REQ_UNUSED_HI = 3'd7;
    localparam logic [SLOT_W-1:0] SLOT_MAX = '1;

    class slot_pool_tracker;
        logic [SLOT_W-1:0] slots [POOL_SIZE];
        logic [TPS_W-1:0]  prescale;
        logic [TPS_W-1:0]  period_cfg;
        logic              enabled;
        stp_rsp_t          expected_q [$];
        int                errors;

        function new();
            foreach (slots[i]) slots[i] = '0;
            prescale   = '0;
            period_cfg = TICKS_RESET;
            enabled    = 1'b0;
            errors     = 0;
        endfunction

        function void set_period(input logic [TPS_W-1:0] v);
            period_cfg = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function bit pool_free();
            foreach (slots[i]) if (slots[i] != '0) return 1'b0;
            return 1'b1;
        endfunction

        function void note_request(input stp_req_t r);
            stp_rsp_t         rsp;
            logic [TPS_W-1:0] period;
            logic [TPS_W-1:0] next_count;
            bit               any_expired;
            rsp = '0;
            any_expired = 1'b0;
            case (req_code_t'(r.req_type))
                REQ_ALLOC: begin
                    for (int s = 0; s < POOL_SIZE; s++) begin
                        if (slots[s] == '0 && !rsp.alloc_ok) begin
                            slots[s]        = SLOT_IDLE;
                            rsp.alloc_ok    = 1'b1;
                            rsp.alloc_index = 2'(s);
                        end
                    end
                end
                REQ_LOAD: begin
                    if (slots[r.timer_index] != '0) slots[r.timer_index] = r.load_value;
                end
                REQ_START: begin
                    if (slots[r.timer_index] != '0) enabled = 1'b1;
                end
                REQ_STOP: begin
                    if (slots[r.timer_index] != '0) begin
                        slots[r.timer_index] = '0;
                        if (pool_free()) enabled = 1'b0;
                    end
                end
                REQ_TICK: begin
                    if (enabled) begin
                        period     = (period_cfg == '0) ? TPS_W'(1) : period_cfg;
                        next_count = prescale + 1'b1;
                        if (next_count >= period) begin
                            prescale = '0;
                            for (int s = 0; s < POOL_SIZE; s++) begin
                                if (slots[s] > SLOT_IDLE) slots[s] = slots[s] - 1'b1;
                                if (slots[s] == SLOT_IDLE) begin
                                    slots[s]            = '0;
                                    any_expired         = 1'b1;
                                    rsp.expired_mask[s] = 1'b1;
                                end
                            end
                            if (any_expired && pool_free()) enabled = 1'b0;
                        end else begin
                            prescale = next_count;
                        end
                    end
                end
                default: ;
            endcase
            rsp.tick_enabled = enabled;
            expected_q.push_back(rsp);
        endfunction

        task report_mismatch(input string what, input int got, input int want);
            $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
            errors++;
        endtask

        task check_response(input stp_rsp_t got);
            stp_rsp_t want;
            if (expected_q.size() == 0) begin
                report_mismatch("response with no request pending", got, 0);
                return;
            end
            want = expected_q.pop_front();
            if (got.alloc_ok !== want.alloc_ok)
                report_mismatch("alloc_ok", got.alloc_ok, want.alloc_ok);
            if (got.alloc_index !== want.alloc_index)
                report_mismatch("alloc_index", got.alloc_index, want.alloc_index);
            if (got.expired_mask !== want.expired_mask)
                report_mismatch("expired_mask", got.expired_mask, want.expired_mask);
            if (got.tick_enabled !== want.tick_enabled)
                report_mismatch("tick_enabled", got.tick_enabled, want.tick_enabled);
        endtask
    endclass

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    stp_req_t         s_data = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    stp_rsp_t         m_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [TPS_W-1:0] cfg_data = '0;

    int               tx_idle_pct = 0;
    int               rx_idle_pct = 0;
    int               quiet_cycles = 0;
    logic [TPS_W-1:0] phase_period [NUM_PHASES];

    slot_pool_tracker tracker = new();

    software_timer_pool #(
        .NUM_TIMERS(POOL_SIZE)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) tracker.check_response(m_data);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic stp_req_t mk(input logic [2:0] code, input logic [1:0] idx,
                                    input logic [SLOT_W-1:0] val);
        stp_req_t r;
        r.req_type    = code;
        r.timer_index = idx;
        r.load_value  = val;
        return r;
    endfunction

    // mostly well-formed traffic aimed at allocated slots, with some noise
    function automatic stp_req_t random_request();
        stp_req_t r;
        int       pick;
        int       start;
        pick = $urandom_range(99);
        r.load_value  = SLOT_W'($urandom_range(0, 32767));
        r.timer_index = 2'($urandom_range(POOL_SIZE - 1));
        if ($urandom_range(9) < 7) begin
            start = $urandom_range(POOL_SIZE - 1);
            for (int k = POOL_SIZE - 1; k >= 0; k--) begin
                if (tracker.slots[(start + k) % POOL_SIZE] != '0)
                    r.timer_index = 2'((start + k) % POOL_SIZE);
            end
        end
        if (pick < 14) begin
            r.req_type = REQ_ALLOC;
        end else if (pick < 28) begin
            r.req_type = REQ_LOAD;
            if ($urandom_range(3) != 0) r.load_value = SLOT_W'($urandom_range(0, 6));
        end else if (pick < 38) begin
            r.req_type = REQ_START;
        end else if (pick < 46) begin
            r.req_type = REQ_STOP;
        end else if (pick < 97) begin
            r.req_type = REQ_TICK;
        end else begin
            r.req_type = 3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
        end
        return r;
    endfunction

    task automatic send_request(input stp_req_t r);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.note_request(r);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_period(input logic [TPS_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        tracker.set_period(v);
    endtask

    initial begin
        stp_req_t         r;
        int               n;
        logic [TPS_W-1:0] period;

        phase_period = '{8'd1, 8'd255, 8'd0, 8'd3, 8'd2, 8'd7, 8'd128, 8'd1, 8'd4};
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle_pct = 23;
        rx_idle_pct = 68;

        // nothing allocated: all ignored, tick disabled
        send_request(mk(REQ_TICK, 2'd0, '0));
        send_request(mk(REQ_STOP, 2'd0, '0));
        send_request(mk(REQ_LOAD, 2'd1, SLOT_MAX));
        send_request(mk(REQ_START, 2'd2, '0));
        repeat (POOL_SIZE + 1) send_request(mk(REQ_ALLOC, 2'd3, SLOT_MAX));
        send_request(mk(REQ_LOAD, 2'd0, SLOT_MAX));
        send_request(mk(REQ_LOAD, 2'd1, SLOT_STEP));
        send_request(mk(REQ_LOAD, 2'd2, '0));
        send_request(mk(REQ_START, 2'd3, '0));
        // fifth tick steps; idle slot and the one counted to 1 expire
        repeat (TICKS_RESET) send_request(mk(REQ_TICK, 2'd0, '0));
        send_request(mk(REQ_UNUSED_HI, 2'd3, SLOT_MAX));
        send_request(mk(REQ_UNUSED_LO, 2'd2, '0));
        send_request(mk(REQ_STOP, 2'd0, '0));
        send_request(mk(REQ_TICK, 2'd1, '0));

        // lower the period below a built-up prescaler count
        write_period(8'd255);
        send_request(mk(REQ_ALLOC, 2'd0, '0));
        send_request(mk(REQ_LOAD, 2'd0, 15'd3));
        send_request(mk(REQ_START, 2'd0, '0));
        repeat (3) send_request(mk(REQ_TICK, 2'd0, '0));
        write_period(8'd2);
        send_request(mk(REQ_TICK, 2'd0, '0));

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph < 3) begin
                tx_idle_pct = 23;
                rx_idle_pct = 68;
            end else if (ph < 6) begin
                tx_idle_pct = 68;
                rx_idle_pct = 23;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            period = phase_period[ph];
            if (ph == 5 || ph == 8) period = TPS_W'($urandom_range(1, 16));
            write_period(period);
            n = 0;
            while (n < PHASE_ITEMS) begin
                r = random_request();
                send_request(r);
                if (r.req_type <= REQ_TICK) n++;
            end
        end

        drain();
        repeat (10) @(posedge aclk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: software_timer_pool.f
hdl/stp_pkg.sv
hdl/stp_in_stage.sv
hdl/stp_free_enc.sv
hdl/stp_pool_core.sv
hdl/software_timer_pool.sv
hdl/stp_checker.sv
verif/tb_software_timer_pool.sv
